/* hdl/ubx_pkg.sv */
// ubx_pkg: shared types, constants and field table for the frame parser
// no dependencies
`timescale 1ns / 1ps
package ubx_pkg;

   localparam int MAX_PAYLOAD_DEF       = 608;
   localparam int MAX_EMIT_CHANNELS_DEF = 16;

   localparam logic [7:0] SYNC1_BYTE = 8'hb5;
   localparam logic [7:0] SYNC2_BYTE = 8'h62;
   localparam logic [7:0] CLASS_NAV  = 8'h01;

   localparam logic [7:0] ID_POSLLH  = 8'd2;
   localparam logic [7:0] ID_STATUS  = 8'd3;
   localparam logic [7:0] ID_DOP     = 8'd4;
   localparam logic [7:0] ID_SOL     = 8'd6;
   localparam logic [7:0] ID_VELNED  = 8'd18;
   localparam logic [7:0] ID_TIMEUTC = 8'd33;
   localparam logic [7:0] ID_SVINFO  = 8'd48;

   localparam logic [4:0] CODE_NUMCH = 5'd19;
   localparam logic [4:0] CODE_CHAN  = 5'd20;
   localparam logic [4:0] CODE_SVID  = 5'd21;
   localparam logic [4:0] CODE_CNO   = 5'd22;
   localparam logic [4:0] CODE_DONE  = 5'd23;

   localparam int SV_BASE   = 8;
   localparam int SV_STRIDE = 12;

   // field kinds: byte count and sign handling
   typedef enum logic [1:0] {
      KIND_U8  = 2'd0,
      KIND_U16 = 2'd1,
      KIND_U32 = 2'd2,
      KIND_S32 = 2'd3
   } kind_type;

   typedef struct packed {
      logic [4:0] code;
      logic [5:0] offset;
      kind_type   kind;
   } field_type;

   // index of fixed-table entries: first entry and count per message
   typedef struct packed {
      logic [4:0] first;
      logic [2:0] count;
   } msg_type;

   localparam int NUM_FIELDS = 24;

   function automatic field_type field_entry(input logic [4:0] idx);
      field_type f;
      f = '{code: 5'd0, offset: 6'd0, kind: KIND_U8};
      case (idx)
         5'd0:  f = '{5'd0,  6'd8,  KIND_S32};
         5'd1:  f = '{5'd1,  6'd4,  KIND_S32};
         5'd2:  f = '{5'd2,  6'd12, KIND_S32};
         5'd3:  f = '{5'd3,  6'd16, KIND_S32};
         5'd4:  f = '{5'd4,  6'd4,  KIND_U8};
         5'd5:  f = '{5'd5,  6'd5,  KIND_U8};
         5'd6:  f = '{5'd6,  6'd12, KIND_U16};
         5'd7:  f = '{5'd7,  6'd10, KIND_U16};
         5'd8:  f = '{5'd8,  6'd47, KIND_U8};
         5'd9:  f = '{5'd9,  6'd4,  KIND_S32};
         5'd10: f = '{5'd10, 6'd8,  KIND_S32};
         5'd11: f = '{5'd11, 6'd12, KIND_S32};
         5'd12: f = '{5'd12, 6'd16, KIND_U32};
         5'd13: f = '{5'd13, 6'd20, KIND_U32};
         5'd14: f = '{5'd14, 6'd24, KIND_S32};
         5'd15: f = '{5'd15, 6'd0,  KIND_U32};
         5'd16: f = '{5'd16, 6'd12, KIND_U16};
         5'd17: f = '{5'd17, 6'd14, KIND_U8};
         5'd18: f = '{5'd18, 6'd15, KIND_U8};
         5'd19: f = '{CODE_NUMCH, 6'd4, KIND_U8};
         default: f = '{code: 5'd0, offset: 6'd0, kind: KIND_U8};
      endcase
      return f;
   endfunction

   function automatic msg_type msg_lookup(input logic [7:0] cls, input logic [7:0] id);
      msg_type m;
      m = '{first: 5'd0, count: 3'd0};
      if (cls == CLASS_NAV) begin
         case (id)
            ID_POSLLH:  m = '{5'd0,  3'd4};
            ID_STATUS:  m = '{5'd4,  3'd2};
            ID_DOP:     m = '{5'd6,  3'd2};
            ID_SOL:     m = '{5'd8,  3'd1};
            ID_VELNED:  m = '{5'd9,  3'd6};
            ID_TIMEUTC: m = '{5'd15, 3'd4};
            ID_SVINFO:  m = '{5'd19, 3'd1};
            default:    m = '{first: 5'd0, count: 3'd0};
         endcase
      end
      return m;
   endfunction

   function automatic logic [2:0] kind_bytes(input kind_type k);
      logic [2:0] n;
      case (k)
         KIND_U8:  n = 3'd1;
         KIND_U16: n = 3'd2;
         default:  n = 3'd4;
      endcase
      return n;
   endfunction

   // controller -> datapath
   typedef struct packed {
      logic       clear_sum;    // class byte: load sums
      logic       add_sum;
      logic       load_class;
      logic       load_id;
      logic       load_len_lo;
      logic       load_len_hi;
      logic       store_byte;
      logic       rd_start;     // begin gathering a field
      logic       rd_step;      // one byte of the field arrives
      logic       rsp_load;     // place gathered field in output register
      logic       rsp_done;     // place closing beat in output register
   } cmd_type;

endpackage

/* hdl/ubx_frame_parser_top.sv */
// ubx_frame_parser_top: one byte per beat in, nav field beats out after a good frame
// order: header and payload bytes are taken as they arrive; after the last checksum
// byte each field is read from payload memory a byte at a time (read issued, then shifted in), then emitted
// throughput: one byte per cycle while receiving; input stalls during emission
// (up to 49 fields plus the closing beat, bounded by MAX_EMIT_CHANNELS)
// reset: synchronous active high, parser returns to sync hunt, no memory clear
// depends on ubx_pkg, ubx_ctrl, ubx_datapath
`timescale 1ns / 1ps
module ubx_frame_parser_top
   import ubx_pkg::*;
#(
   parameter int MAX_PAYLOAD       = MAX_PAYLOAD_DEF,
   parameter int MAX_EMIT_CHANNELS = MAX_EMIT_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_code,
   output logic [3:0]  rsp_channel_index,
   output logic signed [32:0] rsp_field_value,
   output logic [7:0]  rsp_frame_class,
   output logic [7:0]  rsp_frame_id,
   output logic        rsp_last_of_run
);

   cmd_type     cmd;
   logic [7:0]  held_class, held_id, rd_byte;
   logic [15:0] expected_len;
   logic        len_reached, cka_match, ckb_match;
   logic [10:0] rd_addr;
   logic [4:0]  out_code;
   logic [3:0]  out_chan;
   kind_type    out_kind;

   // sequencer: sync hunt, header, payload count, then field walk
   ubx_ctrl #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .MAX_EMIT_CHANNELS(MAX_EMIT_CHANNELS)
   ) u_ctrl (
      .clock, .reset,
      .req_valid, .req_ready,
      .rx_byte(req_rx_byte),
      .held_class, .held_id, .expected_len,
      .len_reached, .cka_match, .ckb_match, .rd_byte,
      .rsp_valid, .rsp_ready,
      .cmd, .rd_addr, .out_code, .out_chan, .out_kind
   );

   // checksum, payload memory and output register
   ubx_datapath #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_dp (
      .clock, .reset, .cmd,
      .rx_byte(req_rx_byte),
      .rd_addr, .out_code, .out_chan, .out_kind,
      .rsp_take(rsp_valid && rsp_ready),
      .held_class, .held_id, .expected_len,
      .len_reached, .cka_match, .ckb_match, .rd_byte,
      .rsp_valid, .rsp_field_code, .rsp_channel_index, .rsp_field_value,
      .rsp_frame_class, .rsp_frame_id, .rsp_last_of_run
   );

endmodule

/* hdl/ubx_datapath.sv */
// ubx_datapath: checksum, header registers, payload memory and field assembly
// depends on ubx_pkg
`timescale 1ns / 1ps
module ubx_datapath
   import ubx_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   localparam int AW = $clog2(MAX_PAYLOAD),
   localparam int LW = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [7:0]    rx_byte,
   input  logic [10:0]   rd_addr,      // byte address of the current read
   input  logic [4:0]    out_code,
   input  logic [3:0]    out_chan,
   input  kind_type      out_kind,
   input  logic          rsp_take,
   output logic [7:0]    held_class,
   output logic [7:0]    held_id,
   output logic [15:0]   expected_len,
   output logic          len_reached,  // this data byte completes the payload
   output logic          cka_match,
   output logic          ckb_match,
   output logic [7:0]    rd_byte,
   output logic          rsp_valid,
   output logic [4:0]    rsp_field_code,
   output logic [3:0]    rsp_channel_index,
   output logic signed [32:0] rsp_field_value,
   output logic [7:0]    rsp_frame_class,
   output logic [7:0]    rsp_frame_id,
   output logic          rsp_last_of_run
);

   logic [7:0]  sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [7:0]  class_ff, id_ff;
   logic [15:0] len_ff;
   logic [LW-1:0] rcv_ff;
   logic [7:0]  mem [MAX_PAYLOAD];
   logic [7:0]  rd_data_ff;
   logic        rd_oob_ff;
   logic [31:0] acc_ff;
   logic        rsp_valid_ff;
   logic [4:0]  code_ff;
   logic [3:0]  chan_ff;
   logic [32:0] val_ff;
   logic        last_ff;
   logic [7:0]  rsp_class_ff, rsp_id_ff;
   logic [32:0] val_in;

   assign sum_a_in = cmd.clear_sum ? rx_byte : sum_a_ff + rx_byte;
   assign sum_b_in = cmd.clear_sum ? rx_byte : sum_b_ff + sum_a_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         class_ff <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         rcv_ff   <= '0;
      end else begin
         if (cmd.clear_sum || cmd.add_sum) begin
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
         end
         if (cmd.load_class)  class_ff <= rx_byte;
         if (cmd.load_id)     id_ff <= rx_byte;
         if (cmd.load_len_lo) len_ff <= {8'd0, rx_byte};
         if (cmd.load_len_hi) begin
            len_ff <= {rx_byte, len_ff[7:0]};
            rcv_ff <= '0;
         end
         if (cmd.store_byte && rcv_ff < LW'(MAX_PAYLOAD)) rcv_ff <= rcv_ff + 1'b1;
      end
   end

   // payload memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.store_byte && rcv_ff < LW'(MAX_PAYLOAD)) mem[rcv_ff[AW-1:0]] <= rx_byte;
      rd_data_ff <= mem[rd_addr < 11'(MAX_PAYLOAD) ? rd_addr[AW-1:0] : '0];
      rd_oob_ff  <= rd_addr >= 11'(MAX_PAYLOAD);
   end

   assign rd_byte = rd_oob_ff ? 8'd0 : rd_data_ff;

   assign len_reached = ({6'd0, rcv_ff} + ((rcv_ff < LW'(MAX_PAYLOAD)) ? 16'd1 : 16'd0))
                        >= len_ff;
   assign cka_match = rx_byte == sum_a_ff;
   assign ckb_match = rx_byte == sum_b_ff;

   // little-endian gather: each byte shifts in from the top
   always_ff @(posedge clock) begin
      if (cmd.rd_start)     acc_ff <= '0;
      else if (cmd.rd_step) acc_ff <= {rd_byte, acc_ff[31:8]};
   end

   always_comb begin
      case (out_kind)
         KIND_U8:  val_in = {25'd0, acc_ff[31:24]};
         KIND_U16: val_in = {17'd0, acc_ff[31:16]};
         KIND_U32: val_in = {1'b0, acc_ff};
         default:  val_in = {acc_ff[31], acc_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load || cmd.rsp_done) rsp_valid_ff <= 1'b1;
      else if (rsp_take) rsp_valid_ff <= 1'b0;
   end

   // class and id are captured with the beat, the next header may arrive under stall
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         code_ff      <= out_code;
         chan_ff      <= out_chan;
         val_ff       <= val_in;
         last_ff      <= 1'b0;
         rsp_class_ff <= class_ff;
         rsp_id_ff    <= id_ff;
      end else if (cmd.rsp_done) begin
         code_ff      <= CODE_DONE;
         chan_ff      <= '0;
         val_ff       <= '0;
         last_ff      <= 1'b1;
         rsp_class_ff <= class_ff;
         rsp_id_ff    <= id_ff;
      end
   end

   assign held_class        = class_ff;
   assign held_id           = id_ff;
   assign expected_len      = len_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_field_code    = code_ff;
   assign rsp_channel_index = chan_ff;
   assign rsp_field_value   = val_ff;
   assign rsp_frame_class   = rsp_class_ff;
   assign rsp_frame_id      = rsp_id_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

/* hdl/ubx_ctrl.sv */
// ubx_ctrl: frame state machine and field emission sequencer
// depends on ubx_pkg
`timescale 1ns / 1ps
module ubx_ctrl
   import ubx_pkg::*;
#(
   parameter int MAX_PAYLOAD       = MAX_PAYLOAD_DEF,
   parameter int MAX_EMIT_CHANNELS = MAX_EMIT_CHANNELS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    rx_byte,
   input  logic [7:0]    held_class,
   input  logic [7:0]    held_id,
   input  logic [15:0]   expected_len,
   input  logic          len_reached,
   input  logic          cka_match,
   input  logic          ckb_match,
   input  logic [7:0]    rd_byte,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   output cmd_type       cmd,
   output logic [10:0]   rd_addr,
   output logic [4:0]    out_code,
   output logic [3:0]    out_chan,
   output kind_type      out_kind
);

   typedef enum logic [12:0] {
      ST_SYNC1 = 13'b0000000000001,
      ST_SYNC2 = 13'b0000000000010,
      ST_CLASS = 13'b0000000000100,
      ST_ID    = 13'b0000000001000,
      ST_LENLO = 13'b0000000010000,
      ST_LENHI = 13'b0000000100000,
      ST_DATA  = 13'b0000001000000,
      ST_CKA   = 13'b0000010000000,
      ST_CKB   = 13'b0000100000000,
      ST_FETCH = 13'b0001000000000,  // issue read of next byte
      ST_GATH  = 13'b0010000000000,  // read data valid, shift in
      ST_EMIT  = 13'b0100000000000,  // wait for output register, load
      ST_DONE  = 13'b1000000000000
   } state_type;

   state_type   state_ff, state_in;
   msg_type     msg_ff, msg_in;
   logic [4:0]  fidx_ff, fidx_in;     // fixed table entry
   logic [2:0]  byte_ff, byte_in;     // byte within field
   logic        sv_ff, sv_in;         // in channel records
   logic [1:0]  sub_ff, sub_in;       // chan, svid, cno
   logic [3:0]  ch_ff, ch_in;
   logic [4:0]  nch_ff, nch_in;       // channels to emit
   logic [10:0] base_ff, base_in;     // channel record base
   field_type   fe;
   logic [2:0]  nbytes;
   logic [5:0]  sub_off;
   logic [7:0]  ncnt;
   logic        take;
   logic        out_free;

   assign take     = req_valid && req_ready;
   assign out_free = !rsp_valid || rsp_ready;
   assign fe       = field_entry(fidx_ff);

   always_comb begin
      case (sub_ff)
         2'd0:    sub_off = 6'd0;
         2'd1:    sub_off = 6'd1;
         default: sub_off = 6'd4;
      endcase
   end

   assign nbytes   = sv_ff ? 3'd1 : kind_bytes(fe.kind);
   assign out_kind = sv_ff ? KIND_U8 : fe.kind;
   assign out_chan = sv_ff ? ch_ff : 4'd0;
   always_comb begin
      if (!sv_ff)               out_code = fe.code;
      else if (sub_ff == 2'd0)  out_code = CODE_CHAN;
      else if (sub_ff == 2'd1)  out_code = CODE_SVID;
      else                      out_code = CODE_CNO;
   end
   assign rd_addr = sv_ff ? base_ff + 11'(sub_off) + 11'(byte_ff)
                          : 11'(fe.offset) + 11'(byte_ff);

   assign ncnt = rd_byte;  // numch value, valid in gather of its single byte

   assign req_ready = (state_ff == ST_SYNC1) || (state_ff == ST_SYNC2) ||
                      (state_ff == ST_CLASS) || (state_ff == ST_ID) ||
                      (state_ff == ST_LENLO) || (state_ff == ST_LENHI) ||
                      (state_ff == ST_DATA) || (state_ff == ST_CKA) ||
                      (state_ff == ST_CKB);

   always_comb begin
      state_in = state_ff;
      msg_in   = msg_ff;
      fidx_in  = fidx_ff;
      byte_in  = byte_ff;
      sv_in    = sv_ff;
      sub_in   = sub_ff;
      ch_in    = ch_ff;
      nch_in   = nch_ff;
      base_in  = base_ff;
      cmd      = '0;
      case (state_ff)
         ST_SYNC1: if (take && rx_byte == SYNC1_BYTE) state_in = ST_SYNC2;
         ST_SYNC2: if (take) state_in = (rx_byte == SYNC2_BYTE) ? ST_CLASS : ST_SYNC1;
         ST_CLASS: if (take) begin
            cmd.clear_sum  = 1'b1;
            cmd.load_class = 1'b1;
            state_in       = ST_ID;
         end
         ST_ID: if (take) begin
            cmd.add_sum = 1'b1;
            cmd.load_id = 1'b1;
            state_in    = ST_LENLO;
         end
         ST_LENLO: if (take) begin
            cmd.add_sum     = 1'b1;
            cmd.load_len_lo = 1'b1;
            state_in        = ST_LENHI;
         end
         ST_LENHI: if (take) begin
            cmd.add_sum     = 1'b1;
            cmd.load_len_hi = 1'b1;
            if ({rx_byte, expected_len[7:0]} > 16'(MAX_PAYLOAD)) state_in = ST_SYNC1;
            else if ({rx_byte, expected_len[7:0]} == 16'd0)      state_in = ST_CKA;
            else                                                 state_in = ST_DATA;
         end
         ST_DATA: if (take) begin
            cmd.add_sum    = 1'b1;
            cmd.store_byte = 1'b1;
            if (len_reached) state_in = ST_CKA;
         end
         ST_CKA: if (take) state_in = cka_match ? ST_CKB : ST_SYNC1;
         ST_CKB: if (take) begin
            if (ckb_match) begin
               msg_in  = msg_lookup(held_class, held_id);
               fidx_in = msg_in.first;
               byte_in = '0;
               sv_in   = 1'b0;
               nch_in  = '0;
               state_in = (msg_in.count == 3'd0) ? ST_DONE : ST_FETCH;
            end else begin
               state_in = ST_SYNC1;
            end
         end
         ST_FETCH: begin
            if (byte_ff == 3'd0) cmd.rd_start = 1'b1;
            state_in = ST_GATH;
         end
         ST_GATH: begin
            cmd.rd_step = 1'b1;
            if (!sv_ff && fe.code == CODE_NUMCH)
               nch_in = (ncnt > 8'(MAX_EMIT_CHANNELS)) ? 5'(MAX_EMIT_CHANNELS) : ncnt[4:0];
            if (byte_ff + 3'd1 == nbytes) begin
               byte_in  = '0;
               state_in = ST_EMIT;
            end else begin
               byte_in  = byte_ff + 3'd1;
               state_in = ST_FETCH;
            end
         end
         ST_EMIT: if (out_free) begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_FETCH;
            if (!sv_ff) begin
               if (fe.code == CODE_NUMCH) begin
                  sv_in   = 1'b1;
                  sub_in  = 2'd0;
                  ch_in   = '0;
                  base_in = 11'(SV_BASE);
                  if (nch_ff == 5'd0) state_in = ST_DONE;
               end else if (fidx_ff + 5'd1 == msg_ff.first + 5'(msg_ff.count)) begin
                  state_in = ST_DONE;
               end else begin
                  fidx_in = fidx_ff + 5'd1;
               end
            end else if (sub_ff != 2'd2) begin
               sub_in = sub_ff + 2'd1;
            end else begin
               sub_in  = 2'd0;
               base_in = base_ff + 11'(SV_STRIDE);
               if (5'(ch_ff) + 5'd1 == nch_ff) state_in = ST_DONE;
               else ch_in = ch_ff + 4'd1;
            end
         end
         ST_DONE: if (out_free) begin
            cmd.rsp_done = 1'b1;
            state_in     = ST_SYNC1;
         end
         default: state_in = ST_SYNC1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
         msg_ff   <= '0;
         fidx_ff  <= '0;
         byte_ff  <= '0;
         sv_ff    <= 1'b0;
         sub_ff   <= '0;
         ch_ff    <= '0;
         nch_ff   <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         msg_ff   <= msg_in;
         fidx_ff  <= fidx_in;
         byte_ff  <= byte_in;
         sv_ff    <= sv_in;
         sub_ff   <= sub_in;
         ch_ff    <= ch_in;
         nch_ff   <= nch_in;
         base_ff  <= base_in;
      end
   end

endmodule

/* hdl/ubx_checker.sv */
// ubx_checker: port-level assertions for the frame parser, bound to the top
// depends on ubx_pkg and ubx_frame_parser_top ports
`timescale 1ns / 1ps
module ubx_checker
   import ubx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_field_code,
   input logic [3:0]  rsp_channel_index,
   input logic signed [32:0] rsp_field_value,
   input logic        rsp_last_of_run
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_code))
      else $error("result changed under stall");

   // closing beat carries the done code and zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_field_code == CODE_DONE && rsp_field_value == 0)
      else $error("bad closing beat");

   // channel index only on channel record fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_code != CODE_CHAN && rsp_field_code != CODE_SVID &&
      rsp_field_code != CODE_CNO |-> rsp_channel_index == 4'd0)
      else $error("stray channel index");

   // no input taken while a non-closing field is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input taken mid-emission");

endmodule

bind ubx_frame_parser_top ubx_checker u_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_field_code, .rsp_channel_index, .rsp_field_value, .rsp_last_of_run
);

/* tb/tb_top.sv */
// tb_top: self-checking bench for ubx_frame_parser_top, frame bytes in, nav field beats out
// keeps its own byte-level parser model and compares every response beat in order
// depends on ubx_pkg and ubx_frame_parser_top
`timescale 1ns / 1ps
module tb_top;
   import ubx_pkg::*;

   localparam int STORE_DEPTH = MAX_PAYLOAD_DEF;
   localparam int CH_LIMIT    = MAX_EMIT_CHANNELS_DEF;
   localparam int DRAIN_WAIT  = 300;
   localparam int HOLD_CYCLES = 400;

   // field codes of the fixed messages
   localparam logic [4:0] F_LAT = 5'd0, F_LON = 5'd1, F_HEIGHT = 5'd2, F_HMSL = 5'd3;
   localparam logic [4:0] F_FIX = 5'd4, F_FLAGS = 5'd5, F_HDOP = 5'd6, F_VDOP = 5'd7;
   localparam logic [4:0] F_SATS = 5'd8, F_VELN = 5'd9, F_VELE = 5'd10, F_VELD = 5'd11;
   localparam logic [4:0] F_SPEED = 5'd12, F_GSPEED = 5'd13, F_HEADING = 5'd14;
   localparam logic [4:0] F_ITOW = 5'd15, F_YEAR = 5'd16, F_MONTH = 5'd17, F_DAY = 5'd18;

   // parser phases of the model
   typedef enum logic [3:0] {
      PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LENLO, PH_LENHI, PH_DATA, PH_CKA, PH_CKB
   } phase_type;

   // frame trailer corruption
   typedef enum int { CK_GOOD, CK_BAD_A, CK_BAD_B } ck_mode_type;

   typedef struct packed {
      logic [4:0]  code;
      logic [3:0]  chan;
      logic [32:0] value;
      logic [7:0]  cls;
      logic [7:0]  id;
      logic        last;
   } field_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_ready = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic [4:0] rsp_field_code;
   logic [3:0] rsp_channel_index;
   logic signed [32:0] rsp_field_value;
   logic [7:0] rsp_frame_class;
   logic [7:0] rsp_frame_id;
   logic rsp_last_of_run;

   ubx_frame_parser_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_field_code(rsp_field_code), .rsp_channel_index(rsp_channel_index),
      .rsp_field_value(rsp_field_value), .rsp_frame_class(rsp_frame_class),
      .rsp_frame_id(rsp_frame_id), .rsp_last_of_run(rsp_last_of_run)
   );

   // model state
   phase_type   m_phase = PH_SYNC1;
   logic [7:0]  m_class = 8'h00, m_id = 8'h00, m_sum_a = 8'h00, m_sum_b = 8'h00;
   logic [15:0] m_len = 16'h0000;
   int          m_rcvd = 0;
   logic [7:0]  m_store [STORE_DEPTH];

   field_beat_type pending_fields [$];
   logic [7:0]  frame_buf [STORE_DEPTH];
   int  failures = 0;
   int  bytes_sent = 0;
   bit  quiet = 1'b0;       // no idling on either side
   bit  hold_req = 1'b0;    // ask the receiver for a long hold-off

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------
   // model of the byte parser
   // ---------------------------------------------------------------
   function automatic logic [31:0] rd8(input int off);
      return (off >= STORE_DEPTH) ? 32'd0 : {24'd0, m_store[off]};
   endfunction

   function automatic logic [31:0] rd16(input int off);
      return rd8(off) | (rd8(off + 1) << 8);
   endfunction

   function automatic logic [31:0] rd32(input int off);
      return rd16(off) | (rd16(off + 2) << 16);
   endfunction

   function automatic logic [32:0] sx(input logic [31:0] v);
      return {v[31], v};
   endfunction

   function automatic logic [32:0] zx(input logic [31:0] v);
      return {1'b0, v};
   endfunction

   task automatic push_field(input logic [4:0] code, input int ch, input logic [32:0] v,
                             input logic last);
      field_beat_type f;
      f = '{code: code, chan: ch[3:0], value: v, cls: m_class, id: m_id, last: last};
      pending_fields.push_back(f);
   endtask

   task automatic predict_frame_fields();
      int cnt;
      int base;
      if (m_class == CLASS_NAV) begin
         case (m_id)
            ID_POSLLH: begin
               push_field(F_LAT, 0, sx(rd32(8)), 1'b0);
               push_field(F_LON, 0, sx(rd32(4)), 1'b0);
               push_field(F_HEIGHT, 0, sx(rd32(12)), 1'b0);
               push_field(F_HMSL, 0, sx(rd32(16)), 1'b0);
            end
            ID_STATUS: begin
               push_field(F_FIX, 0, zx(rd8(4)), 1'b0);
               push_field(F_FLAGS, 0, zx(rd8(5)), 1'b0);
            end
            ID_DOP: begin
               push_field(F_HDOP, 0, zx(rd16(12)), 1'b0);
               push_field(F_VDOP, 0, zx(rd16(10)), 1'b0);
            end
            ID_SOL: push_field(F_SATS, 0, zx(rd8(47)), 1'b0);
            ID_VELNED: begin
               push_field(F_VELN, 0, sx(rd32(4)), 1'b0);
               push_field(F_VELE, 0, sx(rd32(8)), 1'b0);
               push_field(F_VELD, 0, sx(rd32(12)), 1'b0);
               push_field(F_SPEED, 0, zx(rd32(16)), 1'b0);
               push_field(F_GSPEED, 0, zx(rd32(20)), 1'b0);
               push_field(F_HEADING, 0, sx(rd32(24)), 1'b0);
            end
            ID_TIMEUTC: begin
               push_field(F_ITOW, 0, zx(rd32(0)), 1'b0);
               push_field(F_YEAR, 0, zx(rd16(12)), 1'b0);
               push_field(F_MONTH, 0, zx(rd8(14)), 1'b0);
               push_field(F_DAY, 0, zx(rd8(15)), 1'b0);
            end
            ID_SVINFO: begin
               cnt = int'(rd8(4));
               push_field(CODE_NUMCH, 0, zx(rd8(4)), 1'b0);
               if (cnt > CH_LIMIT) cnt = CH_LIMIT;
               for (int c = 0; c < cnt; c++) begin
                  base = SV_BASE + SV_STRIDE * c;
                  push_field(CODE_CHAN, c, zx(rd8(base)), 1'b0);
                  push_field(CODE_SVID, c, zx(rd8(base + 1)), 1'b0);
                  push_field(CODE_CNO, c, zx(rd8(base + 4)), 1'b0);
               end
            end
            default: ;
         endcase
      end
      push_field(CODE_DONE, 0, 33'd0, 1'b1);
   endtask

   task automatic run_checksum(input logic [7:0] b);
      m_sum_a = m_sum_a + b;
      m_sum_b = m_sum_b + m_sum_a;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      case (m_phase)
         PH_SYNC1: if (b == SYNC1_BYTE) m_phase = PH_SYNC2;
         // a wrong second sync byte is not retried as a first one
         PH_SYNC2: m_phase = (b == SYNC2_BYTE) ? PH_CLASS : PH_SYNC1;
         PH_CLASS: begin
            m_class = b; m_sum_a = b; m_sum_b = b; m_phase = PH_ID;
         end
         PH_ID: begin
            m_id = b; run_checksum(b); m_phase = PH_LENLO;
         end
         PH_LENLO: begin
            m_len = {8'h00, b}; run_checksum(b); m_phase = PH_LENHI;
         end
         PH_LENHI: begin
            m_len[15:8] = b; m_rcvd = 0; run_checksum(b);
            if (m_len > STORE_DEPTH) m_phase = PH_SYNC1;
            else if (m_len == 0) m_phase = PH_CKA;
            else m_phase = PH_DATA;
         end
         PH_DATA: begin
            run_checksum(b);
            if (m_rcvd < STORE_DEPTH) begin
               m_store[m_rcvd] = b;
               m_rcvd++;
            end
            if (m_rcvd >= m_len) m_phase = PH_CKA;
         end
         PH_CKA: m_phase = (b == m_sum_a) ? PH_CKB : PH_SYNC1;
         PH_CKB: begin
            if (b == m_sum_b) predict_frame_fields();
            m_phase = PH_SYNC1;
         end
         default: m_phase = PH_SYNC1;
      endcase
   endtask

   // ---------------------------------------------------------------
   // receiver: random ready, long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 15);
      end
   end

   // response checker: each beat against the oldest pending field
   always @(posedge clock) begin
      field_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fields.size() == 0) begin
            $error("unexpected beat: code %0d value %0h", rsp_field_code, rsp_field_value);
            failures++;
         end else begin
            want = pending_fields.pop_front();
            if (rsp_field_code !== want.code) begin
               $error("field_code: expected %0d actual %0d", want.code, rsp_field_code);
               failures++;
            end
            if (rsp_channel_index !== want.chan) begin
               $error("channel_index: expected %0d actual %0d", want.chan, rsp_channel_index);
               failures++;
            end
            if (rsp_field_value !== want.value) begin
               $error("field_value: expected %0h actual %0h", want.value, rsp_field_value);
               failures++;
            end
            if (rsp_frame_class !== want.cls) begin
               $error("frame_class: expected %0h actual %0h", want.cls, rsp_frame_class);
               failures++;
            end
            if (rsp_frame_id !== want.id) begin
               $error("frame_id: expected %0h actual %0h", want.id, rsp_frame_id);
               failures++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b actual %0b", want.last, rsp_last_of_run);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_byte(b);
      bytes_sent++;
   endtask

   // sender pause: nothing offered until every pending field is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_fields.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // fill the payload buffer: 0 random, 1 all zero, 2 all ones
   task automatic fill_payload(input int len, input int mode);
      for (int i = 0; i < len && i < STORE_DEPTH; i++)
         frame_buf[i] = (mode == 1) ? 8'h00 : (mode == 2) ? 8'hff : 8'($urandom);
   endtask

   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                             input ck_mode_type ck);
      logic [7:0] ca, cb;
      logic [15:0] l;
      l = 16'(len);
      ca = 8'h00; cb = 8'h00;
      send_byte(SYNC1_BYTE);
      send_byte(SYNC2_BYTE);
      ca = cls; cb = cls;
      ca += id; cb += ca;
      ca += l[7:0]; cb += ca;
      ca += l[15:8]; cb += ca;
      send_byte(cls);
      send_byte(id);
      send_byte(l[7:0]);
      send_byte(l[15:8]);
      if (len > STORE_DEPTH) return;   // overlong: parser is back hunting
      for (int i = 0; i < len; i++) begin
         ca += frame_buf[i]; cb += ca;
         send_byte(frame_buf[i]);
      end
      send_byte((ck == CK_BAD_A) ? ca ^ 8'(1 << $urandom_range(7)) : ca);
      if (ck != CK_BAD_A)
         send_byte((ck == CK_BAD_B) ? cb ^ 8'(1 << $urandom_range(7)) : cb);
   endtask

   function automatic int nav_length(input logic [7:0] id);
      case (id)
         ID_POSLLH:  return 28;
         ID_STATUS:  return 16;
         ID_DOP:     return 18;
         ID_SOL:     return 52;
         ID_VELNED:  return 36;
         ID_TIMEUTC: return 20;
         default:    return 8;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // channel count above the emit limit; its payload also covers every
   // offset that emission can read, so it runs first
   task automatic test_many_channels();
      quiet = 1'b1;
      fill_payload(SV_BASE + SV_STRIDE * (CH_LIMIT - 1) + 5, 0);
      frame_buf[4] = 8'hff;
      send_frame(CLASS_NAV, ID_SVINFO, SV_BASE + SV_STRIDE * (CH_LIMIT - 1) + 5, CK_GOOD);
      quiet = 1'b0;
      wait_drained();
   endtask

   // signed and unsigned fields with an all-ones payload
   task automatic test_nav_extremes();
      fill_payload(28, 2);
      send_frame(CLASS_NAV, ID_VELNED, 28, CK_GOOD);
      wait_drained();
   endtask

   // zero length, short frame reading stale bytes, overlong drop
   task automatic test_lengths();
      send_frame(CLASS_NAV, ID_POSLLH, 0, CK_GOOD);
      fill_payload(2, 0);
      send_frame(CLASS_NAV, ID_STATUS, 2, CK_GOOD);
      send_frame(CLASS_NAV, ID_STATUS, STORE_DEPTH + 1, CK_GOOD);
      send_frame(CLASS_NAV, ID_STATUS, 16'hffff, CK_GOOD);
      wait_drained();
   endtask

   // bad second sync byte, then bad checksum bytes
   task automatic test_sync_and_checksum();
      send_byte(SYNC1_BYTE);
      send_byte(SYNC1_BYTE);
      send_byte(SYNC2_BYTE);
      fill_payload(6, 0);
      send_frame(CLASS_NAV, ID_STATUS, 6, CK_BAD_A);
      send_frame(CLASS_NAV, ID_STATUS, 6, CK_BAD_B);
      send_frame(CLASS_NAV, ID_STATUS, 6, CK_GOOD);
      wait_drained();
   endtask

   // receiver stalls while frames keep coming, input has to back up
   task automatic test_backpressure();
      hold_req = 1'b1;
      for (int k = 0; k < 2; k++) begin
         fill_payload(6, 0);
         send_frame(CLASS_NAV, ID_STATUS, 6, CK_GOOD);
      end
      wait_drained();
   endtask

   // mostly well-formed frames with random content, some broken ones and noise
   task automatic test_random_stream(input int target);
      logic [7:0] ids [7];
      logic [7:0] id;
      int pick, len, nch, stop;
      ids = '{ID_POSLLH, ID_STATUS, ID_DOP, ID_SOL, ID_VELNED, ID_TIMEUTC, ID_SVINFO};
      stop = bytes_sent + target;
      while (bytes_sent < stop) begin
         pick = $urandom_range(99);
         id = ids[$urandom_range(6)];
         if ($urandom_range(9) == 0) id = 8'($urandom);
         len = nav_length(id);
         nch = 0;
         if (id == ID_SVINFO) begin
            nch = $urandom_range(0, 4);
            len = 8 + SV_STRIDE * nch;
         end
         if ($urandom_range(9) == 0) len = $urandom_range(0, len);
         fill_payload(len, 0);
         if (id == ID_SVINFO && len > 4) frame_buf[4] = 8'(nch);
         if (pick < 70)
            send_frame(($urandom_range(9) == 0) ? 8'($urandom) : CLASS_NAV, id, len, CK_GOOD);
         else if (pick < 80)
            send_frame(CLASS_NAV, id, len, ($urandom_range(1)) ? CK_BAD_A : CK_BAD_B);
         else if (pick < 83)
            send_frame(CLASS_NAV, id, $urandom_range(STORE_DEPTH + 1, 16'hffff), CK_GOOD);
         else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(3) == 0) send_byte(SYNC1_BYTE);
               else send_byte(8'($urandom));
            end
         end
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_many_channels();
      test_nav_extremes();
      test_lengths();
      test_sync_and_checksum();
      test_backpressure();
      test_random_stream(30);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hdl/ubx_pkg.sv
hdl/ubx_datapath.sv
hdl/ubx_ctrl.sv
hdl/ubx_frame_parser_top.sv
hdl/ubx_checker.sv
tb/tb_top.sv
